FILE: hw/rtl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg: send suppression cache package
// Payload types, outcome codes, sequencer states and the key cleaning helper.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int KEY_W      = 64;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

   typedef enum logic [2:0] {
      OUT_ADDED      = 3'd0,
      OUT_CHANGED    = 3'd1,
      OUT_RESENT     = 3'd2,
      OUT_SUPPRESSED = 3'd3,
      OUT_FULL       = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  name_key;
      logic [KEY_W-1:0]  value_key;
      logic [TIME_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic        send_ok;
      outcome_type outcome;
   } rsp_payload_type;

   // keep the top nbytes bytes, zero everything from the first zero byte on
   function automatic logic [KEY_W-1:0] clean_key(input logic [KEY_W-1:0] key,
                                                  input int unsigned nbytes);
      logic [KEY_W-1:0] res;
      logic             ended;
      logic [7:0]       b;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         b = key[KEY_W-1-8*i -: 8];
         if (i >= nbytes || b == 8'd0) begin
            ended = 1'b1;
         end
         if (!ended) begin
            res[KEY_W-1-8*i -: 8] = b;
         end
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/send_suppression_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_suppression_cache: repeat suppression for outgoing messages
// Looks each message name up in an in-order filled table and decides whether
// the message is transmitted or suppressed as a recent unchanged repeat.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. The name table lives in one
// memory with a single registered read port, and the lookup reads it one used
// entry per cycle, stopping at the first matching name or after the last used
// entry. A finished result sits in the output register, and the next item is
// accepted while it waits to be taken; the decision step of that next item
// holds until the register is free. The table holds no valid bits: only
// entries below the fill count are read. repeat_interval is written over the
// csr port, which is ready while the block is idle and no item is offered.
module send_suppression_cache #(
   parameter int ENTRIES     = 16,
   parameter int NAME_BYTES  = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ssc_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ssc_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssc_pkg::INTERVAL_W-1:0]      csr_data
);

   localparam int NAME_W = 8 * NAME_BYTES;
   localparam int VAL_W  = 8 * VALUE_BYTES;
   localparam int TIME_W = ssc_pkg::TIME_W;
   localparam int WORD_W = NAME_W + VAL_W + TIME_W;
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   ssc_pkg::state_type          state_ff, state_in;
   logic [ssc_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [CNT_W-1:0]            addr_ff, addr_in;
   logic                        data_vld_ff, data_vld_in;
   logic [IDX_W-1:0]            data_idx_ff, data_idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [VAL_W-1:0]            hit_val_ff, hit_val_in;
   logic [TIME_W-1:0]           hit_next_ff, hit_next_in;
   logic [NAME_W-1:0]           name_ff, name_in;
   logic [VAL_W-1:0]            val_ff, val_in;
   logic [TIME_W-1:0]           now_ff, now_in;
   logic [TIME_W-1:0]           next_ff, next_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ssc_pkg::rsp_payload_type    rsp_ff, rsp_in;

   logic [ssc_pkg::KEY_W-1:0]   name_clean, val_clean;
   logic                        req_accept;
   logic                        ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   logic [WORD_W-1:0]           ram_wr_data, ram_rd_data;
   logic [NAME_W-1:0]           rd_name;
   logic [VAL_W-1:0]            rd_val;
   logic [TIME_W-1:0]           rd_next;
   logic                        issue;

   assign name_clean = ssc_pkg::clean_key(req_data.name_key, NAME_BYTES);
   assign val_clean  = ssc_pkg::clean_key(req_data.value_key, VALUE_BYTES);

   assign req_stall  = (state_ff != ssc_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // no write while an item is offered, so an item never races a new interval
   assign csr_ready  = (state_ff == ssc_pkg::ST_IDLE) && !req_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign rd_name = ram_rd_data[WORD_W-1 -: NAME_W];
   assign rd_val  = ram_rd_data[VAL_W+TIME_W-1 -: VAL_W];
   assign rd_next = ram_rd_data[TIME_W-1:0];

   assign issue       = (state_ff == ssc_pkg::ST_SCAN) && (addr_ff < fill_ff);
   assign ram_rd_en   = issue;
   assign ram_wr_data = {name_ff, val_ff, next_ff};

   ssc_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (ENTRIES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssc_pkg::ST_IDLE;
         interval_ff  <= ssc_pkg::INTERVAL_RESET;
         fill_ff      <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         fill_ff      <= fill_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      data_idx_ff <= data_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      hit_next_ff <= hit_next_in;
      name_ff     <= name_in;
      val_ff      <= val_in;
      now_ff      <= now_in;
      next_ff     <= next_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      fill_in      = fill_ff;
      addr_in      = addr_ff;
      data_vld_in  = issue;
      data_idx_in  = addr_ff[IDX_W-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      hit_next_in  = hit_next_ff;
      name_in      = name_ff;
      val_in       = val_ff;
      now_in       = now_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_ff[IDX_W-1:0];

      if (csr_valid && csr_ready) begin
         interval_in = csr_data;
      end

      unique case (state_ff)
         ssc_pkg::ST_IDLE: begin
            if (req_accept) begin
               name_in  = name_clean[ssc_pkg::KEY_W-1 -: NAME_W];
               val_in   = val_clean[ssc_pkg::KEY_W-1 -: VAL_W];
               now_in   = req_data.now_ms;
               next_in  = req_data.now_ms + TIME_W'(interval_ff);
               addr_in  = '0;
               hit_in   = 1'b0;
               state_in = ssc_pkg::ST_SCAN;
            end
         end
         ssc_pkg::ST_SCAN: begin
            // reads are pipelined: compare entry data_idx while addr_ff is read
            if (data_vld_ff && rd_name == name_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = data_idx_ff;
               hit_val_in  = rd_val;
               hit_next_in = rd_next;
               state_in    = ssc_pkg::ST_DECIDE;
            end else if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end else if (!data_vld_ff) begin
               state_in = ssc_pkg::ST_DECIDE;
            end
         end
         ssc_pkg::ST_DECIDE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_in.send_ok = 1'b1;
               state_in       = ssc_pkg::ST_IDLE;
               priority if (hit_ff && hit_val_ff != val_ff) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = hit_idx_ff;
                  rsp_in.outcome = ssc_pkg::OUT_CHANGED;
               end else if (hit_ff && now_ff > hit_next_ff) begin
                  ram_wr_en      = 1'b1;
                  ram_wr_addr    = hit_idx_ff;
                  rsp_in.outcome = ssc_pkg::OUT_RESENT;
               end else if (hit_ff) begin
                  rsp_in.send_ok = 1'b0;
                  rsp_in.outcome = ssc_pkg::OUT_SUPPRESSED;
               end else if (fill_ff < FULL_COUNT) begin
                  ram_wr_en      = 1'b1;
                  fill_in        = fill_ff + CNT_W'(1);
                  rsp_in.outcome = ssc_pkg::OUT_ADDED;
               end else begin
                  rsp_in.outcome = ssc_pkg::OUT_FULL;
               end
            end
         end
         default: begin
            state_in = ssc_pkg::ST_IDLE;
         end
      endcase
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count beyond table size");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ssc_pkg::ST_SCAN)
      else $error("accepted item did not start a lookup");

   a_send_matches_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.send_ok == (rsp_ff.outcome != ssc_pkg::OUT_SUPPRESSED)))
      else $error("send flag disagrees with outcome");

   a_fill_only_on_add: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         (rsp_valid_ff && rsp_ff.outcome == ssc_pkg::OUT_ADDED))
      else $error("table grew without an added outcome");

endmodule

FILE: hw/rtl/ssc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_ram: generic single write port ram
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/send_suppression_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_suppression_checker: result checker for the send suppression cache
// Watches the request, result and csr channels, keeps its own copy of the
// name table and repeat interval, predicts the decision for every accepted
// item and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module send_suppression_checker #(
   parameter int ENTRIES     = 16,
   parameter int NAME_BYTES  = 8,
   parameter int VALUE_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  ssc_pkg::req_payload_type       req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  ssc_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ssc_pkg::INTERVAL_W-1:0] csr_data,
   output int                             pending,
   output int                             errors
);

   localparam int KEY_W      = ssc_pkg::KEY_W;
   localparam int TIME_W     = ssc_pkg::TIME_W;
   localparam int INTERVAL_W = ssc_pkg::INTERVAL_W;

   logic [KEY_W-1:0]          known_name  [ENTRIES];
   logic [KEY_W-1:0]          known_value [ENTRIES];
   logic [TIME_W-1:0]         quiet_until [ENTRIES];
   int                        used;
   logic [INTERVAL_W-1:0]     interval_ms;
   ssc_pkg::rsp_payload_type  decision_q [$];
   ssc_pkg::rsp_payload_type  want;

   // mask off everything from the first zero byte on and every byte past the byte limit
   function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] key,
                                                 input int nbytes);
      logic [KEY_W-1:0] keep;
      logic             alive;
      keep  = '0;
      alive = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i >= nbytes || key[KEY_W-1-8*i -: 8] == 8'h00) begin
            alive = 1'b0;
         end
         if (alive) begin
            keep[KEY_W-1-8*i -: 8] = 8'hFF;
         end
      end
      return key & keep;
   endfunction

   // decide one message and update the table the way the block should
   function automatic ssc_pkg::rsp_payload_type judge_message(
         input ssc_pkg::req_payload_type m);
      logic [KEY_W-1:0]          nm;
      logic [KEY_W-1:0]          vl;
      logic [TIME_W-1:0]         due;
      int                        hit;
      ssc_pkg::rsp_payload_type  v;
      nm  = trim_key(m.name_key, NAME_BYTES);
      vl  = trim_key(m.value_key, VALUE_BYTES);
      due = m.now_ms + TIME_W'(interval_ms);
      hit = -1;
      for (int i = 0; i < used; i++) begin
         if (hit < 0 && known_name[i] == nm) begin
            hit = i;
         end
      end
      v.send_ok = 1'b1;
      if (hit >= 0) begin
         if (known_value[hit] != vl) begin
            known_value[hit] = vl;
            quiet_until[hit] = due;
            v.outcome        = ssc_pkg::OUT_CHANGED;
         end else if (m.now_ms > quiet_until[hit]) begin
            quiet_until[hit] = due;
            v.outcome        = ssc_pkg::OUT_RESENT;
         end else begin
            v.send_ok = 1'b0;
            v.outcome = ssc_pkg::OUT_SUPPRESSED;
         end
      end else if (used < ENTRIES) begin
         known_name[used]  = nm;
         known_value[used] = vl;
         quiet_until[used] = due;
         used++;
         v.outcome = ssc_pkg::OUT_ADDED;
      end else begin
         v.outcome = ssc_pkg::OUT_FULL;
      end
      return v;
   endfunction

   task automatic flag_mismatch(input string msg);
      errors++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         used        = 0;
         interval_ms = ssc_pkg::INTERVAL_RESET;
         errors      = 0;
         decision_q.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            interval_ms = csr_data;
         end
         if (req_valid && !req_stall) begin
            decision_q.push_back(judge_message(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (decision_q.size() == 0) begin
               flag_mismatch($sformatf("result send_ok=%0d outcome=%0d with none expected",
                                       rsp_data.send_ok, rsp_data.outcome));
            end else begin
               want = decision_q.pop_front();
               if (rsp_data.send_ok !== want.send_ok) begin
                  flag_mismatch($sformatf("send_ok %0d, expected %0d",
                                          rsp_data.send_ok, want.send_ok));
               end
               if (rsp_data.outcome !== want.outcome) begin
                  flag_mismatch($sformatf("outcome %0d, expected %0d",
                                          rsp_data.outcome, want.outcome));
               end
            end
         end
         pending <= decision_q.size();
      end
   end

endmodule

FILE: sim/tb_send_suppression_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_send_suppression_cache: testbench for the send suppression cache
// Directed messages for each decision and key cleaning corner, then random
// message streams over a small name pool under several repeat intervals and
// idling patterns. Checking is done by send_suppression_checker.
// ----------------------------------------------------------------------------
module tb_send_suppression_cache;

   localparam int ENTRIES         = 16;
   localparam int NAME_BYTES      = 8;
   localparam int VALUE_BYTES     = 8;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 305;
   localparam int STALL_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 2 * ENTRIES + 8;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   ssc_pkg::req_payload_type       req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   ssc_pkg::rsp_payload_type       rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [ssc_pkg::INTERVAL_W-1:0] csr_data  = '0;

   int          pending;
   int          errors;
   int          idle_run      = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          interval_now  = ssc_pkg::INTERVAL_RESET;
   logic [31:0] stamp         = '0;
   int          interval_plan [PHASES];

   send_suppression_cache #(
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES),
      .VALUE_BYTES(VALUE_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   send_suppression_checker #(
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES),
      .VALUE_BYTES(VALUE_BYTES)
   ) checker_i (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .pending  (pending),
      .errors   (errors)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // ends the run when no handshake of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("[send_suppression_cache] ERROR");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   // pool names: every fourth fills all eight bytes, the rest end early with junk after
   function automatic logic [63:0] pool_name(input int k);
      logic [7:0]  kb;
      logic [63:0] junk;
      kb   = k[7:0];
      junk = {$urandom, $urandom};
      if (k % 4 == 0) begin
         return {8'h50 + kb, 48'h6162_6364_6566, 8'h67 + kb};
      end
      return {8'h4E, 8'h41 + kb, 8'h00, junk[39:0]};
   endfunction

   // names that end up in the table: pool 0..12 plus the three directed names
   function automatic logic [63:0] table_name(input int k);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      case (k)
         13:      return '1;
         14:      return {8'h00, junk[55:0]};
         15:      return {16'h4142, 8'h00, junk[39:0]};
         default: return pool_name(k);
      endcase
   endfunction

   // mostly one favorite value so that repeats are common
   function automatic logic [63:0] pick_value();
      logic [63:0] junk;
      int          r;
      int          sel;
      logic [7:0]  sb;
      junk = {$urandom, $urandom};
      r    = $urandom_range(0, 99);
      if (r < 5) begin
         return junk;
      end
      sel = (r < 60) ? 1 : $urandom_range(0, 4);
      sb  = sel[7:0];
      case (sel)
         0:       return {8'h00, junk[55:0]};
         4:       return 64'h3132_3334_3536_3738;
         default: return {8'h30 + sb, 8'h00, junk[47:0]};
      endcase
   endfunction

   task automatic send_msg(input logic [63:0] nm, input logic [63:0] vl,
                           input logic [31:0] t);
      ssc_pkg::req_payload_type item;
      item.name_key  = nm;
      item.value_key = vl;
      item.now_ms    = t;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random();
      logic [63:0] nm;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         nm = table_name($urandom_range(0, 15));
      end else if (r < 95) begin
         nm = pool_name($urandom_range(13, 19));
      end else begin
         nm = {$urandom, $urandom};
      end
      if ($urandom_range(0, 99) < 3) begin
         stamp = $urandom;
      end else begin
         stamp = stamp + $urandom_range(0, interval_now / 8 + 2);
      end
      send_msg(nm, pick_value(), stamp);
   endtask

   // wait until every predicted result has been taken
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_interval(input int v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v[ssc_pkg::INTERVAL_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      interval_now  = v;
   endtask

   initial begin
      interval_plan = '{0, 65535, 250, $urandom_range(2, 65534), 1, 1000};
      send_idle_pct = 38;
      recv_idle_pct = 79;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset interval of 1000: add, equal at the boundary, resend, change
      send_msg('1, 64'h0, 32'd0);
      send_msg('1, 64'h00FF_FFFF_FFFF_FFFF, 32'd1000);
      send_msg('1, 64'h0, 32'd1001);
      send_msg('1, '1, 32'd1002);
      // empty name, next send time wraps past zero
      send_msg(64'h0, 64'h4100_0000_0000_0000, 32'hFFFF_FFFF);
      send_msg(64'h00AB_CDEF_0123_4567, 64'h4100_5A5A_0000_0001, 32'd999);
      send_msg(64'h0, 64'h4100_0000_0000_0000, 32'd1000);
      // bytes after a zero byte do not count in names or values
      send_msg(64'h4142_0058_0000_0000, 64'h5631_0000_0000_0000, 32'd10);
      send_msg(64'h4142_0059_1234_5678, 64'h5631_007A_7A00_0000, 32'd20);
      send_msg(64'h4142_0000_0000_0000, 64'h5632_0000_0000_0000, 32'd30);
      // fill the table, then unknown names find it full
      for (int k = 0; k < 13; k++) begin
         send_msg(pool_name(k), pick_value(), 32'd40 + k);
      end
      send_msg(pool_name(13), pick_value(), 32'd60);
      send_msg(pool_name(14), pick_value(), 32'd61);

      stamp = 32'd100;
      for (int p = 0; p < PHASES; p++) begin
         write_interval(interval_plan[p]);
         if (p < 2) begin
            send_idle_pct = 38;
            recv_idle_pct = 79;
         end else if (p < 4) begin
            send_idle_pct = 79;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (ITEMS_PER_PHASE) send_random();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[send_suppression_cache] OK");
      end else begin
         $display("[send_suppression_cache] ERROR");
      end
      $finish;
   end

endmodule
